@@ rtl/zes_pkg.sv @@
// zes_pkg: shared widths, layer edge ROM and elaboration-time table builders
// for the ziggurat exponential sampler. No dependencies.
package zes_pkg;

	localparam int LAYER_COUNT = 128;
	localparam int LAYER_W = 7;
	localparam int UNIFORM_BITS_DEF = 32;
	localparam int FRAC_W = 32;
	localparam int TAU_W = 24;
	localparam int OUT_W = 40;
	localparam int X_W = 36;       // layer edges and candidates, Q4.32
	localparam int Y_W = 33;       // exp values, up to 1.0 in Q.32
	localparam int V_W = 38;       // tail sums, Q6.32
	localparam int OUT_SHIFT = 21;

	localparam logic [63:0] DEC_ONE = 64'd1000000000000;
	localparam logic [63:0] LN2_Q32 = 64'hB17217F8;
	localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
	localparam logic [63:0] TAIL_COEF_DEC = 64'd873390718750;

	localparam int EXP_TERMS = 24;
	localparam int EXP_N_MAX = 23;
	localparam int EXP_N_W = 5;
	localparam int LN_TERMS = 16;
	localparam int LN_NORM_STEPS = 5;
	localparam int LN_S_W = 5;
	localparam int DIV_STEPS = 32;

	localparam int EXP_LAT = 2 + 2 * EXP_TERMS + 1;
	localparam int LN_LAT = LN_NORM_STEPS + DIV_STEPS + 1 + 2 * LN_TERMS + 1;

	typedef logic [63:0] dec_tab_t [LAYER_COUNT];
	typedef logic [X_W-1:0] edge_tab_t [LAYER_COUNT];
	typedef logic [Y_W-1:0] yexp_tab_t [LAYER_COUNT];

	localparam dec_tab_t EDGE_DEC = '{
		64'd0, 64'd91339518102, 64'd150952685936, 64'd198733655529,
		64'd240088052723, 64'd277325069275, 64'd311666667258, 64'd343847188566,
		64'd374346987428, 64'd403499951515, 64'd431549022036, 64'd458677399489,
		64'd485027265694, 64'd510711613728, 64'd535822045250, 64'd560434093304,
		64'd584610965138, 64'd608406241612, 64'd631865867316, 64'd655029646251,
		64'd677932385146, 64'd700604780753, 64'd723074117839, 64'd745364825026,
		64'd767498922393, 64'd789496385605, 64'd811375444921, 64'd833152832880,
		64'd854843991130, 64'd876463244467, 64'd898023948333, 64'd919538614677,
		64'd941019020056, 64'd962476299071, 64'd983921025635, 64'd1005363284060,
		64'd1026812731645, 64'd1048278654074, 64'd1069770014772, 64'd1091295499122,
		64'd1112863554340, 64'd1134482425639, 64'd1156160189262, 64'd1177904782835,
		64'd1199724033454, 64'd1221625683865, 64'd1243617417025, 64'd1265706879329,
		64'd1287901702726, 64'd1310209525953, 64'd1332638015055, 64'd1355194883392,
		64'd1377887911267, 64'd1400724965346, 64'd1423714017999, 64'd1446863166707,
		64'd1470180653652, 64'd1493674885639, 64'd1517354454465, 64'd1541228157870,
		64'd1565305021202, 64'd1589594319943, 64'd1614105603228, 64'd1638848718514,
		64'd1663833837574, 64'd1689071483969, 64'd1714572562210, 64'd1740348388796,
		64'd1766410725373, 64'd1792771814244, 64'd1819444416521, 64'd1846441853208,
		64'd1873778049570, 64'd1901467583154, 64'd1929525735892, 64'd1957968550772,
		64'd1986812893606, 64'd2016076520511, 64'd2045778151801, 64'd2075937553080,
		64'd2106575624428, 64'd2137714498734, 64'd2169377650349, 64'd2201590015429,
		64'd2234378125560, 64'd2267770256497, 64'd2301796594139, 64'd2336489420262,
		64'd2371883320906, 64'd2408015420863, 64'd2444925648337, 64'd2482657034573,
		64'd2521256054197, 64'd2560773013129, 64'd2601262492307, 64'd2642783857191,
		64'd2685401845136, 64'd2729187245421, 64'd2774217690067, 64'd2820578577915,
		64'd2868364159859, 64'd2917678820286, 64'd2968638598903, 64'd3021373009291,
		64'd3076027226488, 64'd3132764737386, 64'd3191770576737, 64'd3253255311385,
		64'd3317459990569, 64'd3384662357961, 64'd3455184732396, 64'd3529404126123,
		64'd3607765409372, 64'd3690798693076, 64'd3779142663756, 64'd3873576497597,
		64'd3975064441378, 64'd4084819616805, 64'd4204397939328, 64'd4335840994085,
		64'd4481902072262, 64'd4646421132862, 64'd4834984367324, 64'd5056174148798,
		64'd5324182373137, 64'd5665072466085, 64'd6135192844501, 64'd6898315116615
	};

	// decimal (1e-12 units) to Q.32, rounded half up
	function automatic logic [63:0] dec_to_q32(input logic [63:0] d);
		logic [63:0] whole;
		logic [63:0] rm;
		logic [63:0] frac;
		whole = d / DEC_ONE;
		rm = d % DEC_ONE;
		frac = '0;
		for (int i = 0; i < 33; i++) begin
			rm = rm << 1;
			frac = frac << 1;
			if (rm >= DEC_ONE) begin
				rm = rm - DEC_ONE;
				frac = frac | 64'd1;
			end
		end
		frac = (frac + 64'd1) >> 1;
		return (whole << 32) + frac;
	endfunction

	// bitwise long division, elaboration only
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] rm;
		q = '0;
		rm = '0;
		for (int i = 63; i >= 0; i--) begin
			rm = {rm[62:0], num[i]};
			if (rm >= den) begin
				rm = rm - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] exp_neg_const(input logic [63:0] v);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] sum;
		n = v / LN2_Q32;
		r = v - n * LN2_Q32;
		term = ONE_Q32;
		sum = ONE_Q32;
		if (n >= 64'd40)
			return 64'd0;
		for (int k = 1; k <= EXP_TERMS; k++) begin
			term = long_div((term * r) >> 32, 64'(k));
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum >> n;
	endfunction

	function automatic edge_tab_t build_edges();
		edge_tab_t t;
		for (int i = 0; i < LAYER_COUNT; i++)
			t[i] = X_W'(dec_to_q32(EDGE_DEC[i]));
		return t;
	endfunction

	function automatic yexp_tab_t build_yexp();
		yexp_tab_t t;
		for (int i = 0; i < LAYER_COUNT; i++)
			t[i] = Y_W'(exp_neg_const(dec_to_q32(EDGE_DEC[i])));
		return t;
	endfunction

	localparam edge_tab_t EDGE_Q32 = build_edges();
	localparam yexp_tab_t EDGE_EXP = build_yexp();
	localparam logic [FRAC_W-1:0] TAIL_COEF_Q32 = FRAC_W'(dec_to_q32(TAIL_COEF_DEC));

endpackage

@@ rtl/zes_exp_unit.sv @@
// zes_exp_unit: pipelined exp(-v), range reduction by ln2 then a 24-term
// Taylor series, two stages per term. Depends on zes_pkg.
module zes_exp_unit import zes_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [X_W-1:0] v,
	output logic [Y_W-1:0] e
);

	logic [EXP_N_MAX-1:0]  above;
	logic [X_W-1:0]        v_s1;
	logic [EXP_N_W-1:0]    n_s1;
	logic [EXP_N_W-1:0]    n_s2;
	logic [FRAC_W-1:0]     r_s2;
	logic [X_W-1:0]        nl;

	logic [2*FRAC_W:0]     prod_a  [1:EXP_TERMS];
	logic [Y_W:0]          sum_a   [1:EXP_TERMS];
	logic [FRAC_W-1:0]     r_a     [1:EXP_TERMS];
	logic [EXP_N_W-1:0]    n_a     [1:EXP_TERMS];
	logic [2*FRAC_W+1:0]   dprod_b [1:EXP_TERMS];
	logic [Y_W:0]          sum_b   [1:EXP_TERMS];
	logic [FRAC_W-1:0]     r_b     [1:EXP_TERMS];
	logic [EXP_N_W-1:0]    n_b     [1:EXP_TERMS];

	logic [Y_W-1:0]        term_f;
	logic [Y_W:0]          sum_f;
	logic [Y_W-1:0]        e_q;

	// n = floor(v / ln2), capped at EXP_N_MAX, as a thermometer count
	always_comb begin
		for (int i = 0; i < EXP_N_MAX; i++)
			above[i] = (64'(v) >= 64'(i + 1) * LN2_Q32);
	end

	assign nl = X_W'(64'(n_s1) * LN2_Q32);

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= v;
			n_s1 <= EXP_N_W'($countones(above));
			r_s2 <= FRAC_W'(v_s1 - nl);
			n_s2 <= n_s1;
		end
	end

	for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
		localparam int D = k;
		localparam int L = $clog2(D);
		localparam logic [FRAC_W+1:0] M = (FRAC_W+2)'(((64'd1 << (FRAC_W + L)) / D) + 1);
		logic [Y_W-1:0]     term_in;
		logic [Y_W:0]       sum_in;
		logic [FRAC_W-1:0]  r_in;
		logic [EXP_N_W-1:0] n_in;

		if (k == 1) begin : g_first
			assign term_in = Y_W'(ONE_Q32);
			assign sum_in = (Y_W+1)'(ONE_Q32);
			assign r_in = r_s2;
			assign n_in = n_s2;
		end else begin : g_next
			localparam int DP = k - 1;
			localparam int LP = $clog2(DP);
			assign term_in = Y_W'(dprod_b[k-1] >> (FRAC_W + LP));
			if (DP % 2 == 1) begin : g_sub
				assign sum_in = sum_b[k-1] - (Y_W+1)'(term_in);
			end else begin : g_add
				assign sum_in = sum_b[k-1] + (Y_W+1)'(term_in);
			end
			assign r_in = r_b[k-1];
			assign n_in = n_b[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prod_a[k] <= (2*FRAC_W+1)'(term_in) * (2*FRAC_W+1)'(r_in);
				sum_a[k] <= sum_in;
				r_a[k] <= r_in;
				n_a[k] <= n_in;
				dprod_b[k] <= (2*FRAC_W+2)'(prod_a[k][FRAC_W +: FRAC_W]) * (2*FRAC_W+2)'(M);
				sum_b[k] <= sum_a[k];
				r_b[k] <= r_a[k];
				n_b[k] <= n_a[k];
			end
		end
	end

	localparam int LF = $clog2(EXP_TERMS);
	assign term_f = Y_W'(dprod_b[EXP_TERMS] >> (FRAC_W + LF));

	if (EXP_TERMS % 2 == 1) begin : g_fsub
		assign sum_f = sum_b[EXP_TERMS] - (Y_W+1)'(term_f);
	end else begin : g_fadd
		assign sum_f = sum_b[EXP_TERMS] + (Y_W+1)'(term_f);
	end

	always_ff @(posedge clk) begin
		if (en)
			e_q <= Y_W'(sum_f >> n_b[EXP_TERMS]);
	end

	assign e = e_q;

endmodule

@@ rtl/zes_ln_unit.sv @@
// zes_ln_unit: pipelined -ln(1 - f): normalize, radix-2 divide for
// q = (1-w)/(1+w), then a 16-term odd series. Depends on zes_pkg.
module zes_ln_unit import zes_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [FRAC_W-1:0] f,
	output logic [V_W-1:0]    nl
);

	logic [FRAC_W-1:0] w_n  [LN_NORM_STEPS];
	logic [LN_S_W-1:0] s_n  [LN_NORM_STEPS];
	logic              z_n  [LN_NORM_STEPS];

	logic [FRAC_W:0]   rem_d [DIV_STEPS];
	logic [FRAC_W:0]   den_d [DIV_STEPS];
	logic [FRAC_W-1:0] q_d   [DIV_STEPS];
	logic [LN_S_W-1:0] s_d   [DIV_STEPS];
	logic              z_d   [DIV_STEPS];

	logic [FRAC_W-1:0] p_s;
	logic [FRAC_W-1:0] p2_s;
	logic [LN_S_W-1:0] s_s;
	logic              z_s;

	logic [2*FRAC_W-1:0] m1_a  [LN_TERMS];
	logic [2*FRAC_W+1:0] m2_a  [LN_TERMS];
	logic [FRAC_W:0]     sum_a [LN_TERMS];
	logic [FRAC_W-1:0]   p2_a  [LN_TERMS];
	logic [LN_S_W-1:0]   s_a   [LN_TERMS];
	logic                z_a   [LN_TERMS];
	logic [FRAC_W-1:0]   p_b   [LN_TERMS];
	logic [FRAC_W:0]     sum_b [LN_TERMS];
	logic [FRAC_W-1:0]   p2_b  [LN_TERMS];
	logic [LN_S_W-1:0]   s_b   [LN_TERMS];
	logic                z_b   [LN_TERMS];

	logic [V_W-1:0]      nl_q;

	// leading-zero normalize, widest shift first
	for (genvar j = 0; j < LN_NORM_STEPS; j++) begin : g_norm
		localparam int SH = 1 << (LN_NORM_STEPS - 1 - j);
		logic [FRAC_W-1:0] w_in;
		logic [LN_S_W-1:0] s_in;
		logic              z_in;
		logic              zero_top;

		if (j == 0) begin : g_first
			assign w_in = FRAC_W'(0) - f;
			assign s_in = '0;
			assign z_in = (f == '0);
		end else begin : g_next
			assign w_in = w_n[j-1];
			assign s_in = s_n[j-1];
			assign z_in = z_n[j-1];
		end

		assign zero_top = (w_in[FRAC_W-1 -: SH] == '0);

		always_ff @(posedge clk) begin
			if (en) begin
				w_n[j] <= zero_top ? (w_in << SH) : w_in;
				s_n[j] <= zero_top ? (s_in + LN_S_W'(SH)) : s_in;
				z_n[j] <= z_in;
			end
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [FRAC_W:0]   rem_in;
		logic [FRAC_W:0]   den_in;
		logic [FRAC_W-1:0] q_in;
		logic [LN_S_W-1:0] s_in;
		logic              z_in;
		logic [FRAC_W+1:0] rem2;
		logic              ge;

		if (j == 0) begin : g_first
			assign den_in = {1'b1, w_n[LN_NORM_STEPS-1]};
			assign rem_in = (FRAC_W+1)'(ONE_Q32) - {1'b0, w_n[LN_NORM_STEPS-1]};
			assign q_in = '0;
			assign s_in = s_n[LN_NORM_STEPS-1];
			assign z_in = z_n[LN_NORM_STEPS-1];
		end else begin : g_next
			assign den_in = den_d[j-1];
			assign rem_in = rem_d[j-1];
			assign q_in = q_d[j-1];
			assign s_in = s_d[j-1];
			assign z_in = z_d[j-1];
		end

		assign rem2 = {rem_in, 1'b0};
		assign ge = (rem2 >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[j] <= ge ? (FRAC_W+1)'(rem2 - {1'b0, den_in}) : (FRAC_W+1)'(rem2);
				den_d[j] <= den_in;
				q_d[j] <= {q_in[FRAC_W-2:0], ge};
				s_d[j] <= s_in;
				z_d[j] <= z_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s <= q_d[DIV_STEPS-1];
			p2_s <= FRAC_W'((64'(q_d[DIV_STEPS-1]) * 64'(q_d[DIV_STEPS-1])) >> FRAC_W);
			s_s <= s_d[DIV_STEPS-1];
			z_s <= z_d[DIV_STEPS-1];
		end
	end

	// series: sum of p/(2i+1), p advancing by q^2
	for (genvar i = 0; i < LN_TERMS; i++) begin : g_ser
		localparam int D = 2 * i + 1;
		localparam int L = $clog2(D);
		localparam logic [FRAC_W+1:0] M = (FRAC_W+2)'(((64'd1 << (FRAC_W + L)) / D) + 1);
		logic [FRAC_W-1:0] p_in;
		logic [FRAC_W-1:0] p2_in;
		logic [FRAC_W:0]   sum_in;
		logic [LN_S_W-1:0] s_in;
		logic              z_in;

		if (i == 0) begin : g_first
			assign p_in = p_s;
			assign p2_in = p2_s;
			assign sum_in = '0;
			assign s_in = s_s;
			assign z_in = z_s;
		end else begin : g_next
			assign p_in = p_b[i-1];
			assign p2_in = p2_b[i-1];
			assign sum_in = sum_b[i-1];
			assign s_in = s_b[i-1];
			assign z_in = z_b[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m1_a[i] <= (2*FRAC_W)'(p_in) * (2*FRAC_W)'(p2_in);
				m2_a[i] <= (2*FRAC_W+2)'(p_in) * (2*FRAC_W+2)'(M);
				sum_a[i] <= sum_in;
				p2_a[i] <= p2_in;
				s_a[i] <= s_in;
				z_a[i] <= z_in;
				p_b[i] <= m1_a[i][FRAC_W +: FRAC_W];
				sum_b[i] <= sum_a[i] + (FRAC_W+1)'(m2_a[i] >> (FRAC_W + L));
				p2_b[i] <= p2_a[i];
				s_b[i] <= s_a[i];
				z_b[i] <= z_a[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_b[LN_TERMS-1])
				nl_q <= '0;
			else
				nl_q <= V_W'(64'(s_b[LN_TERMS-1]) * LN2_Q32)
					+ V_W'({sum_b[LN_TERMS-1], 1'b0});
		end
	end

	assign nl = nl_q;

endmodule

@@ rtl/ziggurat_exponential_sampler_core.sv @@
// ziggurat_exponential_sampler_core: one ziggurat attempt per input beat.
// Path: S1-S4, the -ln depth the exp path pads to, F1, F2, output register.
// Throughput: one attempt per cycle while no stalled sample holds the pipe; the
// depth is set by the -ln pipeline (normalize, 32-stage divider, 16-term series).
// Reset clears valid bits and loads scale_tau with 1.0; data regs are not reset.
// Depends on zes_pkg, zes_exp_unit, zes_ln_unit.
module ziggurat_exponential_sampler_core import zes_pkg::*; #(
	parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// attempt beats
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [LAYER_W-1:0] layer_index,
	input  logic [FRAC_W-1:0]  uniform_first,
	input  logic [FRAC_W-1:0]  uniform_second,
	// sample beats
	output logic               out_valid,
	input  logic               out_stall,
	output logic [OUT_W-1:0]   sample_value,
	// scale_tau register
	input  logic               cfg_wr_en,
	input  logic [TAU_W-1:0]   cfg_wr_data
);

	// only the top UNIFORM_BITS of each fraction count
	localparam int KEEP = (UNIFORM_BITS < FRAC_W) ? UNIFORM_BITS : FRAC_W;
	localparam logic [FRAC_W-1:0] FRAC_MASK =
		~((FRAC_W'(1) << (FRAC_W - KEEP)) - FRAC_W'(1));
	localparam int EXP_PAD = LN_LAT - EXP_LAT;
	localparam logic [X_W-1:0] XT = EDGE_Q32[LAYER_COUNT-1];
	localparam logic [TAU_W-1:0] TAU_RESET = TAU_W'(65536);
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	// what the item needs after the exp / ln units
	localparam logic [1:0] MODE_ACCEPT = 2'd0;   // inside inner edge or base rectangle
	localparam logic [1:0] MODE_TEST   = 2'd1;   // wedge: compare y against exp(-u)
	localparam logic [1:0] MODE_TAIL   = 2'd2;   // u = x127 - ln(1 - f2)

	typedef struct packed {
		logic [1:0]     mode;
		logic [X_W-1:0] upre;
		logic [Y_W-1:0] y;
	} side_t;

	logic [TAU_W-1:0] tau_q;
	logic             adv;

	// S1: input capture
	logic               v_s1;
	logic [LAYER_W-1:0] k_s1;
	logic [FRAC_W-1:0]  f1_s1, f2_s1;

	// S2: ROM lookups
	logic               v_s2;
	logic [X_W-1:0]     xl_s2, xh_s2;
	logic [Y_W-1:0]     yl_s2, band_s2;
	logic               last_s2, tailsel_s2;
	logic [FRAC_W-1:0]  f1_s2, f2_s2;
	logic [LAYER_W-1:0] k_next;
	logic [Y_W-1:0]     yh_c, yl_c;

	// S3: products
	logic               v_s3;
	logic [X_W-1:0]     u_s3, urect_s3, xl_s3;
	logic [Y_W-1:0]     y_s3;
	logic               last_s3, tailsel_s3;
	logic [FRAC_W-1:0]  f2_s3;

	// S4: classification, feeds both units
	logic               v_s4;
	side_t              side_s4;
	logic [FRAC_W-1:0]  f2_s4;

	logic [Y_W-1:0]     exp_raw;
	logic [V_W-1:0]     ln_out;
	logic [Y_W-1:0]     exp_pad_q [EXP_PAD];
	side_t              side_q    [LN_LAT];
	logic               vd_q      [LN_LAT];
	side_t              side_l;
	logic [Y_W-1:0]     exp_l;

	// F1/F2: accept decision, tau product
	logic                   v_f1;
	logic [V_W-1:0]         u_f1;
	logic                   v_f2;
	logic [V_W+TAU_W-1:0]   prod_f2;
	logic [V_W+TAU_W-OUT_SHIFT-1:0] scaled;
	logic                   acc_c;

	logic               out_valid_q;
	logic [OUT_W-1:0]   sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tau_q <= TAU_RESET;
		else if (cfg_wr_en)
			tau_q <= cfg_wr_data;
	end

	// Whole pipe moves unless a finished sample would overwrite a stalled one.
	assign adv = !(out_valid_q && out_stall && v_f2);
	assign in_stall = !adv;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < LN_LAT; i++)
				vd_q[i] <= 1'b0;
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vd_q[0] <= v_s4;
			for (int i = 1; i < LN_LAT; i++)
				vd_q[i] <= vd_q[i-1];
			v_f1 <= vd_q[LN_LAT-1] && acc_c;
			v_f2 <= v_f1;
		end
	end

	assign k_next = k_s1 + LAYER_W'(1);
	assign yh_c = EDGE_EXP[k_s1];
	assign yl_c = EDGE_EXP[k_next];

	always_ff @(posedge clk) begin
		if (adv) begin
			// S1
			k_s1 <= layer_index;
			f1_s1 <= uniform_first & FRAC_MASK;
			f2_s1 <= uniform_second & FRAC_MASK;
			// S2: edges x[k], x[k+1]; band y[k] - y[k+1]
			xl_s2 <= EDGE_Q32[k_s1];
			xh_s2 <= EDGE_Q32[k_next];
			yl_s2 <= yl_c;
			band_s2 <= (yh_c > yl_c) ? (yh_c - yl_c) : '0;
			last_s2 <= (k_s1 == LAYER_W'(LAYER_COUNT - 1));
			tailsel_s2 <= (f1_s1 > TAIL_COEF_Q32);
			f1_s2 <= f1_s1;
			f2_s2 <= f2_s1;
			// S3: u = x[k+1]*f1, y = band*f2 + y[k+1], base rectangle x127*f2
			u_s3 <= X_W'(((X_W+FRAC_W)'(xh_s2) * (X_W+FRAC_W)'(f1_s2)) >> FRAC_W);
			y_s3 <= Y_W'(((Y_W+FRAC_W)'(band_s2) * (Y_W+FRAC_W)'(f2_s2)) >> FRAC_W)
				+ yl_s2;
			urect_s3 <= X_W'(((X_W+FRAC_W)'(XT) * (X_W+FRAC_W)'(f2_s2)) >> FRAC_W);
			xl_s3 <= xl_s2;
			last_s3 <= last_s2;
			tailsel_s3 <= tailsel_s2;
			f2_s3 <= f2_s2;
			// S4
			if (last_s3) begin
				side_s4.mode <= tailsel_s3 ? MODE_TAIL : MODE_ACCEPT;
				side_s4.upre <= tailsel_s3 ? XT : urect_s3;
			end else begin
				side_s4.mode <= (u_s3 > xl_s3) ? MODE_TEST : MODE_ACCEPT;
				side_s4.upre <= u_s3;
			end
			side_s4.y <= y_s3;
			f2_s4 <= f2_s3;
			// side data rides along the unit latency
			side_q[0] <= side_s4;
			for (int i = 1; i < LN_LAT; i++)
				side_q[i] <= side_q[i-1];
			exp_pad_q[0] <= exp_raw;
			for (int i = 1; i < EXP_PAD; i++)
				exp_pad_q[i] <= exp_pad_q[i-1];
			// F1
			case (side_l.mode)
				MODE_TAIL: u_f1 <= V_W'(side_l.upre) + ln_out;
				default:   u_f1 <= V_W'(side_l.upre);
			endcase
			// F2
			prod_f2 <= (V_W+TAU_W)'(u_f1) * (V_W+TAU_W)'(tau_q);
		end
	end

	zes_exp_unit u_exp (
		.clk (clk),
		.en  (adv),
		.v   (side_s4.upre),
		.e   (exp_raw)
	);

	zes_ln_unit u_ln (
		.clk (clk),
		.en  (adv),
		.f   (f2_s4),
		.nl  (ln_out)
	);

	assign side_l = side_q[LN_LAT-1];
	assign exp_l = exp_pad_q[EXP_PAD-1];

	// wedge rejects when y lies above the curve
	always_comb begin
		case (side_l.mode)
			MODE_TEST: acc_c = (side_l.y <= exp_l);
			default:   acc_c = 1'b1;
		endcase
	end

	assign scaled = prod_f2[V_W+TAU_W-1:OUT_SHIFT];

	// output register: holds a sample while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && v_f2)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && v_f2)
			sample_q <= (scaled > (V_W+TAU_W-OUT_SHIFT)'(OUT_MAX)) ? OUT_MAX : OUT_W'(scaled);
	end

	assign out_valid = out_valid_q;
	assign sample_value = sample_q;

	// input is held back only while a sample sits stalled at the output
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with no blocked sample");

	// a taken sample with nothing behind it leaves the output empty
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !v_f2) |=> !out_valid)
		else $error("output stayed valid after being taken");

	// a held pipe keeps its first stage
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && in_stall) |=> (v_s1 && $stable(k_s1) && $stable(f2_s1)))
		else $error("first stage changed during stall");

endmodule
